// File: rtl/vna_pkg.sv
`default_nettype none
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int POS_W        = 24;
  localparam int DIFF_W       = POS_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int ACC_W        = 56;
  localparam int NRM_W        = 16;
  localparam int MAG_W        = 40;
  localparam int HALF_W       = MAG_W / 2;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam int KBIT_W       = 17;
  localparam int SRCH_W       = SUM_W + 2 * (KBIT_W - 1) + 3;
  localparam int SCALE_SH     = 32;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pos_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] z;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] x;
  } acc_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] z;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] x;
  } cross_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
    logic                    zero;
  } nres_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRI_RA,
    ST_TRI_RB,
    ST_TRI_RC,
    ST_TRI_CAP,
    ST_TRI_MUL,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_REQ,
    ST_RD_CAP,
    ST_RD_NORM,
    ST_RD_OUT
  } vna_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SUM,
    N_INIT,
    N_CAND,
    N_CMP,
    N_DONE
  } nrm_state_t;

  // saturating accumulate, overflow seen as disagreeing top bits
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]   a,
    input logic signed [CROSS_W-1:0] c
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W + 1 - CROSS_W){c[CROSS_W-1]}}, c};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/vna_if.sv
`default_nettype none
interface vna_in_if;
  import vna_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [VIDX_W-1:0]       vertex_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [VIDX_W-1:0]       corner_a;
  logic [VIDX_W-1:0]       corner_b;
  logic [VIDX_W-1:0]       corner_c;

  modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
  import vna_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [VIDX_W-1:0]       read_index;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    zero_normal;

  modport source (output valid, read_index, normal_x, normal_y, normal_z, zero_normal,
                  input ready);
  modport sink   (input valid, read_index, normal_x, normal_y, normal_z, zero_normal,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/vna_ram.sv
`default_nettype none
module vna_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  localparam int DEPTH = 1 << AW;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/vna_cross.sv
`default_nettype none
module vna_cross (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire vna_pkg::pos_t  p0,
  input  wire vna_pkg::pos_t  p1,
  input  wire vna_pkg::pos_t  p2,
  output logic                done,
  output vna_pkg::cross_t     cross_out
);
  import vna_pkg::*;

  logic signed [DIFF_W-1:0] ux_r, uy_r, uz_r, wx_r, wy_r, wz_r;
  logic                     busy_r;
  logic [2:0]               iss_r;
  logic                     pv_r;
  logic [2:0]               tag_r;
  logic signed [PROD_W-1:0] prod_r, first_r;
  logic signed [DIFF_W-1:0] ma, mb;
  logic                     done_r;
  cross_t                   cross_r;

  // six products, paired into the three components
  always_comb begin
    case (iss_r)
      3'd0:    begin ma = uy_r; mb = wz_r; end
      3'd1:    begin ma = uz_r; mb = wy_r; end
      3'd2:    begin ma = uz_r; mb = wx_r; end
      3'd3:    begin ma = ux_r; mb = wz_r; end
      3'd4:    begin ma = ux_r; mb = wy_r; end
      3'd5:    begin ma = uy_r; mb = wx_r; end
      default: begin ma = '0;   mb = '0;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      iss_r  <= '0;
    end else begin
      done_r <= 1'b0;
      pv_r   <= busy_r;
      if (start) begin
        busy_r <= 1'b1;
        iss_r  <= '0;
      end else if (busy_r) begin
        if (iss_r == 3'd5) begin
          busy_r <= 1'b0;
        end
        iss_r <= iss_r + 3'd1;
      end
      if (pv_r && tag_r == 3'd5) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ux_r <= DIFF_W'(p1.x) - DIFF_W'(p0.x);
      uy_r <= DIFF_W'(p1.y) - DIFF_W'(p0.y);
      uz_r <= DIFF_W'(p1.z) - DIFF_W'(p0.z);
      wx_r <= DIFF_W'(p2.x) - DIFF_W'(p0.x);
      wy_r <= DIFF_W'(p2.y) - DIFF_W'(p0.y);
      wz_r <= DIFF_W'(p2.z) - DIFF_W'(p0.z);
    end
    prod_r <= ma * mb;
    tag_r  <= iss_r;
    if (pv_r) begin
      if (!tag_r[0]) begin
        first_r <= prod_r;
      end else begin
        case (tag_r[2:1])
          2'd0:    cross_r.x <= CROSS_W'(first_r) - CROSS_W'(prod_r);
          2'd1:    cross_r.y <= CROSS_W'(first_r) - CROSS_W'(prod_r);
          default: cross_r.z <= CROSS_W'(first_r) - CROSS_W'(prod_r);
        endcase
      end
    end
  end

  assign done      = done_r;
  assign cross_out = cross_r;
endmodule
`default_nettype wire

// File: rtl/vna_norm.sv
`default_nettype none
module vna_norm (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire vna_pkg::acc_t acc,
  output logic               done,
  output vna_pkg::nres_t     res
);
  import vna_pkg::*;

  nrm_state_t state_r, state_nxt;

  logic [ACC_W-1:0]        mag_r [3];
  logic [2:0]              neg_r;
  logic [SQ_W-1:0]         sq_r [3];
  logic [SUM_W-1:0]        s_r;
  logic [SRCH_W-1:0]       p_r, qs_r, ss_r, cand_r;
  logic [KBIT_W-1:0]       k_r;
  logic [4:0]              j_r;
  logic [1:0]              c_r;
  logic [1:0]              comp_r, part_r, pcomp_r, ppart_r;
  logic                    iss_done_r, pv_r;
  logic [2*HALF_W-1:0]     prod_r;
  logic signed [NRM_W-1:0] nrm_r [3];
  logic                    zero_r;

  logic [MAG_W-1:0]        mcur;
  logic [HALF_W-1:0]       ma, mb;
  logic [SQ_W-1:0]         sq_add;
  logic                    big;
  logic [SRCH_W-1:0]       y2;
  logic                    take;
  logic [KBIT_W-1:0]       k_fin;
  logic [KBIT_W:0]         r_full;
  logic [KBIT_W-1:0]       r_val;
  logic signed [NRM_W-1:0] q15;

  assign big = (|mag_r[0][ACC_W-1:MAG_W]) | (|mag_r[1][ACC_W-1:MAG_W])
             | (|mag_r[2][ACC_W-1:MAG_W]);

  // square of a 40-bit magnitude from three half-width products
  always_comb begin
    mcur = mag_r[comp_r][MAG_W-1:0];
    case (part_r)
      2'd0:    begin ma = mcur[HALF_W-1:0];     mb = mcur[HALF_W-1:0]; end
      2'd1:    begin ma = mcur[MAG_W-1:HALF_W]; mb = mcur[HALF_W-1:0]; end
      default: begin ma = mcur[MAG_W-1:HALF_W]; mb = mcur[MAG_W-1:HALF_W]; end
    endcase
    case (ppart_r)
      2'd0:    sq_add = SQ_W'(prod_r);
      2'd1:    sq_add = SQ_W'(prod_r) << (HALF_W + 1);
      default: sq_add = SQ_W'(prod_r) << MAG_W;
    endcase
  end

  // largest k with k*k*S <= 2^32*m*m, output is (k+1)/2
  always_comb begin
    y2     = SRCH_W'({sq_r[c_r], {SCALE_SH{1'b0}}});
    take   = (cand_r <= y2);
    k_fin  = take ? (k_r | (KBIT_W'(1) << j_r)) : k_r;
    r_full = ({1'b0, k_fin} + (KBIT_W + 1)'(1)) >> 1;
    r_val  = r_full[KBIT_W-1:0];
    if (neg_r[c_r]) begin
      q15 = NRM_W'(~r_val + KBIT_W'(1));
    end else if (r_val > KBIT_W'(32767)) begin
      q15 = NRM_W'(32767);
    end else begin
      q15 = r_val[NRM_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:  if (start) begin
        state_nxt = (acc == '0) ? N_DONE : N_SHIFT;
      end
      N_SHIFT: if (!big) state_nxt = N_SQ;
      N_SQ:    if (pv_r && pcomp_r == 2'd2 && ppart_r == 2'd2) state_nxt = N_SUM;
      N_SUM:   state_nxt = N_INIT;
      N_INIT:  state_nxt = N_CAND;
      N_CAND:  state_nxt = N_CMP;
      N_CMP:   begin
        if (j_r != 5'd0) state_nxt = N_CAND;
        else if (c_r == 2'd2) state_nxt = N_DONE;
        else state_nxt = N_INIT;
      end
      N_DONE:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= ma * mb;
    pcomp_r <= comp_r;
    ppart_r <= part_r;
    pv_r    <= 1'b0;
    unique case (state_r)
      N_IDLE: if (start) begin
        neg_r  <= {acc.z[ACC_W-1], acc.y[ACC_W-1], acc.x[ACC_W-1]};
        mag_r[0] <= acc.x[ACC_W-1] ? ACC_W'(-acc.x) : ACC_W'(acc.x);
        mag_r[1] <= acc.y[ACC_W-1] ? ACC_W'(-acc.y) : ACC_W'(acc.y);
        mag_r[2] <= acc.z[ACC_W-1] ? ACC_W'(-acc.z) : ACC_W'(acc.z);
        zero_r <= (acc == '0);
        nrm_r[0] <= '0;
        nrm_r[1] <= '0;
        nrm_r[2] <= '0;
      end
      N_SHIFT: begin
        if (big) begin
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end else begin
          comp_r     <= '0;
          part_r     <= '0;
          iss_done_r <= 1'b0;
          sq_r[0]    <= '0;
          sq_r[1]    <= '0;
          sq_r[2]    <= '0;
        end
      end
      N_SQ: begin
        pv_r <= !iss_done_r;
        if (!iss_done_r) begin
          if (part_r == 2'd2) begin
            part_r <= '0;
            if (comp_r == 2'd2) iss_done_r <= 1'b1;
            else comp_r <= comp_r + 2'd1;
          end else begin
            part_r <= part_r + 2'd1;
          end
        end
        if (pv_r) begin
          sq_r[pcomp_r] <= sq_r[pcomp_r] + sq_add;
        end
      end
      N_SUM: begin
        s_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
        c_r <= '0;
      end
      N_INIT: begin
        p_r  <= '0;
        qs_r <= '0;
        ss_r <= SRCH_W'({s_r, {SCALE_SH{1'b0}}});
        k_r  <= '0;
        j_r  <= 5'(KBIT_W - 1);
      end
      N_CAND: cand_r <= p_r + qs_r + ss_r;
      N_CMP: begin
        if (take) begin
          p_r  <= cand_r;
          qs_r <= (qs_r >> 1) + ss_r;
        end else begin
          qs_r <= qs_r >> 1;
        end
        ss_r <= ss_r >> 2;
        k_r  <= k_fin;
        j_r  <= j_r - 5'd1;
        if (j_r == 5'd0) begin
          nrm_r[c_r] <= q15;
          c_r        <= c_r + 2'd1;
        end
      end
      N_DONE:  ;
      default: ;
    endcase
  end

  assign done     = (state_r == N_DONE);
  assign res.x    = nrm_r[0];
  assign res.y    = nrm_r[1];
  assign res.z    = nrm_r[2];
  assign res.zero = zero_r;
endmodule
`default_nettype wire

// File: rtl/vertex_normal_accumulator.sv
// vertex_normal_accumulator: area-weighted vertex normals over a mesh of up to
// 1024 vertices
// in_ch carries one command per transaction: load a position (also clears the
// vertex normal), add a triangle, or read a vertex normal. out_ch carries one
// transaction per read: index, unit normal in signed Q1.15, zero flag.
// throughput is one command at a time, in_ch.ready is high only when idle:
//   load      handled in the idle state itself
//   triangle  three position reads, six products through one
//             25x25 multiplier, then a read and a write-back per corner
//   read      in the normaliser: up to 16 shift steps,
//             nine 20x20 products for the squares, then a shift-add search of
//             17 steps for each of the three components
//   opcode 3  handled in the idle state, no transaction on out_ch
// after reset the accumulator memory is cleared, one entry a cycle: in_ch
// stays not ready until all 1024 entries are cleared. positions are not cleared.
// a finished result sits in the output register; the block accepts new
// commands while the receiver stalls, and only a second read waits for it
// out_ch.valid holds with a stable payload until out_ch.ready is seen
`default_nettype none
module vertex_normal_accumulator (
  input  wire logic clk,
  input  wire logic rst_n,
  vna_in_if.sink    in_ch,
  vna_out_if.source out_ch
);
  import vna_pkg::*;

  vna_state_t state_r, state_nxt;

  // latched command
  logic [VIDX_W-1:0] vi_r, ca_r, cb_r, cc_r;
  logic [1:0]        k_r;
  logic [VIDX_W-1:0] clr_r;
  pos_t              pa_r, pb_r;

  // memory ports
  logic              pos_we, pos_re;
  logic [VIDX_W-1:0] pos_raddr;
  pos_t              pos_wdata, pos_rdata;
  logic              acc_we, acc_re;
  logic [VIDX_W-1:0] acc_waddr, acc_raddr;
  acc_t              acc_wdata, acc_rdata;

  logic              in_acc;
  logic [VIDX_W-1:0] corner_sel;
  logic              cross_start, cross_done, norm_start, norm_done;
  cross_t            cross_vec;
  nres_t             nres;
  logic              out_load;

  // output register
  logic                    out_valid_r;
  logic [VIDX_W-1:0]       out_idx_r;
  logic signed [NRM_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                    out_zero_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    case (k_r)
      2'd0:    corner_sel = ca_r;
      2'd1:    corner_sel = cb_r;
      default: corner_sel = cc_r;
    endcase
  end

  // position memory: written by loads, read for the three corners
  assign pos_we      = in_acc && (in_ch.operation == OP_LOAD);
  assign pos_wdata.x = in_ch.pos_x;
  assign pos_wdata.y = in_ch.pos_y;
  assign pos_wdata.z = in_ch.pos_z;
  assign pos_re      = (state_r == ST_TRI_RA) || (state_r == ST_TRI_RB)
                    || (state_r == ST_TRI_RC);
  always_comb begin
    case (state_r)
      ST_TRI_RA: pos_raddr = ca_r;
      ST_TRI_RB: pos_raddr = cb_r;
      default:   pos_raddr = cc_r;
    endcase
  end

  // accumulator memory: clearing sweep, load clear, corner write-back
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = corner_sel;
    acc_wdata = '0;
    if (state_r == ST_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_r;
    end else if (pos_we) begin
      acc_we    = 1'b1;
      acc_waddr = in_ch.vertex_index;
    end else if (state_r == ST_ACC_WR) begin
      acc_we      = 1'b1;
      acc_wdata.x = sat_add(acc_rdata.x, cross_vec.x);
      acc_wdata.y = sat_add(acc_rdata.y, cross_vec.y);
      acc_wdata.z = sat_add(acc_rdata.z, cross_vec.z);
    end
  end
  assign acc_re    = (state_r == ST_ACC_RD) || (state_r == ST_RD_REQ);
  assign acc_raddr = (state_r == ST_RD_REQ) ? vi_r : corner_sel;

  assign cross_start = (state_r == ST_TRI_CAP);
  assign norm_start  = (state_r == ST_RD_CAP);
  assign out_load    = (state_r == ST_RD_OUT) && (!out_valid_r || out_ch.ready);

  vna_ram #(.W($bits(pos_t)), .AW(VIDX_W)) u_pos_mem (
    .clk   (clk),
    .we    (pos_we),
    .waddr (in_ch.vertex_index),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vna_ram #(.W($bits(acc_t)), .AW(VIDX_W)) u_acc_mem (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  vna_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cross_start),
    .p0        (pa_r),
    .p1        (pb_r),
    .p2        (pos_rdata),
    .done      (cross_done),
    .cross_out (cross_vec)
  );

  vna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .acc   (acc_rdata),
    .done  (norm_done),
    .res   (nres)
  );

  // sequencer: each accumulator write lands before the next read of it
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (&clr_r) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_acc) begin
        if (in_ch.operation == OP_TRI) state_nxt = ST_TRI_RA;
        else if (in_ch.operation == OP_READ) state_nxt = ST_RD_REQ;
      end
      ST_TRI_RA:  state_nxt = ST_TRI_RB;
      ST_TRI_RB:  state_nxt = ST_TRI_RC;
      ST_TRI_RC:  state_nxt = ST_TRI_CAP;
      ST_TRI_CAP: state_nxt = ST_TRI_MUL;
      ST_TRI_MUL: if (cross_done) state_nxt = ST_ACC_RD;
      ST_ACC_RD:  state_nxt = ST_ACC_WR;
      ST_ACC_WR:  state_nxt = (k_r == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_RD_REQ:  state_nxt = ST_RD_CAP;
      ST_RD_CAP:  state_nxt = ST_RD_NORM;
      ST_RD_NORM: if (norm_done) state_nxt = ST_RD_OUT;
      ST_RD_OUT:  if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + VIDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vi_r <= in_ch.vertex_index;
      ca_r <= in_ch.corner_a;
      cb_r <= in_ch.corner_b;
      cc_r <= in_ch.corner_c;
      k_r  <= '0;
    end
    if (state_r == ST_TRI_RB) pa_r <= pos_rdata;
    if (state_r == ST_TRI_RC) pb_r <= pos_rdata;
    if (state_r == ST_ACC_WR) k_r  <= k_r + 2'd1;
    if (out_load) begin
      out_idx_r  <= vi_r;
      out_x_r    <= nres.x;
      out_y_r    <= nres.y;
      out_z_r    <= nres.z;
      out_zero_r <= nres.zero;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_index  = out_idx_r;
  assign out_ch.normal_x    = out_x_r;
  assign out_ch.normal_y    = out_y_r;
  assign out_ch.normal_z    = out_z_r;
  assign out_ch.zero_normal = out_zero_r;

  // a result only appears after the normaliser has finished
  a_out_from_norm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RD_OUT))
    else $error("result raised outside the output state");

  // no command is taken during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_acc)
    else $error("command accepted while clearing");

  // unit completions only while the sequencer waits for them
  a_cross_done: assert property (@(posedge clk) disable iff (!rst_n)
    cross_done |-> (state_r == ST_TRI_MUL))
    else $error("cross product finished out of sequence");

  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> (state_r == ST_RD_NORM))
    else $error("normaliser finished out of sequence");

  // corner write-back never overlaps a load clear
  a_wb_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC_WR) |-> !pos_we)
    else $error("accumulator write collision");
endmodule
`default_nettype wire

// File: sim/vna_checker.sv
`default_nettype none
module vna_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  vna_in_if         in_ch,
  vna_out_if        out_ch,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  typedef struct {
    logic [VIDX_W-1:0]       idx;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    zero;
  } normal_t;

  longint  vx_mem [MAX_VERTICES];
  longint  vy_mem [MAX_VERTICES];
  longint  vz_mem [MAX_VERTICES];
  longint  sum_x [MAX_VERTICES];
  longint  sum_y [MAX_VERTICES];
  longint  sum_z [MAX_VERTICES];
  normal_t expected_normals [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // clamp to the accumulator width
  function automatic longint clamp_add(longint a, longint c);
    longint hi_lim;
    longint s;
    hi_lim = (longint'(1) <<< (ACC_W - 1)) - 1;
    s = a + c;
    if (s > hi_lim) return hi_lim;
    if (s < -hi_lim - 1) return -hi_lim - 1;
    return s;
  endfunction

  // round(32768*m/sqrt(s)), ties away from zero, by exact search
  function automatic logic signed [NRM_W-1:0] unit_component(
    logic [63:0] m, logic [127:0] s, logic neg);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [127:0] odd;
    logic [127:0] rhs;
    lo  = 0;
    hi  = 32768;
    rhs = ({64'd0, m} * {64'd0, m}) << 32;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 128'(2 * mid - 1);
      if (s * odd * odd <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (neg) return NRM_W'(-int'(lo));
    return (lo > 32767) ? 16'sd32767 : NRM_W'(lo);
  endfunction

  function automatic normal_t normalise(logic [VIDX_W-1:0] idx, longint ax, longint ay,
                                        longint az);
    normal_t      n;
    logic [63:0]  mx;
    logic [63:0]  my;
    logic [63:0]  mz;
    logic [127:0] s;
    n.idx  = idx;
    n.nx   = '0;
    n.ny   = '0;
    n.nz   = '0;
    n.zero = 1'b1;
    mx = (ax < 0) ? 64'(-ax) : 64'(ax);
    my = (ay < 0) ? 64'(-ay) : 64'(ay);
    mz = (az < 0) ? 64'(-az) : 64'(az);
    if (mx == 0 && my == 0 && mz == 0) return n;
    while ((mx >> MAG_W) != 0 || (my >> MAG_W) != 0 || (mz >> MAG_W) != 0) begin
      mx = mx >> 1;
      my = my >> 1;
      mz = mz >> 1;
    end
    s = {64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my} + {64'd0, mz} * {64'd0, mz};
    n.nx   = unit_component(mx, s, ax < 0);
    n.ny   = unit_component(my, s, ay < 0);
    n.nz   = unit_component(mz, s, az < 0);
    n.zero = 1'b0;
    return n;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic apply_command();
    int     a;
    int     b;
    int     c;
    longint ux;
    longint uy;
    longint uz;
    longint wx;
    longint wy;
    longint wz;
    longint cx;
    longint cy;
    longint cz;
    int     vi;
    vi = in_ch.vertex_index;
    case (op_t'(in_ch.operation))
      OP_LOAD: begin
        vx_mem[vi] = in_ch.pos_x;
        vy_mem[vi] = in_ch.pos_y;
        vz_mem[vi] = in_ch.pos_z;
        sum_x[vi]  = 0;
        sum_y[vi]  = 0;
        sum_z[vi]  = 0;
      end
      OP_TRI: begin
        a  = in_ch.corner_a;
        b  = in_ch.corner_b;
        c  = in_ch.corner_c;
        ux = vx_mem[b] - vx_mem[a];
        uy = vy_mem[b] - vy_mem[a];
        uz = vz_mem[b] - vz_mem[a];
        wx = vx_mem[c] - vx_mem[a];
        wy = vy_mem[c] - vy_mem[a];
        wz = vz_mem[c] - vz_mem[a];
        cx = uy * wz - uz * wy;
        cy = uz * wx - ux * wz;
        cz = ux * wy - uy * wx;
        // corners in turn, a repeated corner gets the sum twice
        sum_x[a] = clamp_add(sum_x[a], cx);
        sum_y[a] = clamp_add(sum_y[a], cy);
        sum_z[a] = clamp_add(sum_z[a], cz);
        sum_x[b] = clamp_add(sum_x[b], cx);
        sum_y[b] = clamp_add(sum_y[b], cy);
        sum_z[b] = clamp_add(sum_z[b], cz);
        sum_x[c] = clamp_add(sum_x[c], cx);
        sum_y[c] = clamp_add(sum_y[c], cy);
        sum_z[c] = clamp_add(sum_z[c], cz);
      end
      OP_READ: begin
        expected_normals.push_back(normalise(in_ch.vertex_index, sum_x[vi], sum_y[vi],
                                             sum_z[vi]));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    normal_t want;
    if (!rst_n) begin
      foreach (sum_x[i]) begin
        sum_x[i]  = 0;
        sum_y[i]  = 0;
        sum_z[i]  = 0;
        vx_mem[i] = 0;
        vy_mem[i] = 0;
        vz_mem[i] = 0;
      end
      expected_normals.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) apply_command();
      if (out_ch.valid && out_ch.ready) begin
        if (expected_normals.size() == 0) begin
          $display("[%0t] unexpected normal for vertex %0d", $time, out_ch.read_index);
          errors++;
        end else begin
          want = expected_normals.pop_front();
          if (out_ch.read_index !== want.idx)
            report_mismatch("read_index", out_ch.read_index, want.idx);
          if (out_ch.normal_x !== want.nx) report_mismatch("normal_x", out_ch.normal_x, want.nx);
          if (out_ch.normal_y !== want.ny) report_mismatch("normal_y", out_ch.normal_y, want.ny);
          if (out_ch.normal_z !== want.nz) report_mismatch("normal_z", out_ch.normal_z, want.nz);
          if (out_ch.zero_normal !== want.zero)
            report_mismatch("zero_normal", out_ch.zero_normal, want.zero);
        end
      end
    end
    pending = expected_normals.size();
  end

endmodule
`default_nettype wire

// File: sim/tb_vertex_normal_accumulator.sv
`default_nettype none
module tb_vertex_normal_accumulator;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  localparam int TARGET_CMDS = 1100;
  localparam int CYCLE_LIMIT = 900000;  // clearing pass plus slow reads, several times over
  localparam int DRAIN_WAIT  = 300;     // longer than one read through the normaliser
  localparam int POS_MAX     = 8388607;
  localparam int POS_MIN     = -8388608;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   cycles;
  int   n_load;
  int   n_tri;
  int   n_read;
  int   n_junk;
  int   burst_left;
  int   sat_runs;
  bit   loaded [MAX_VERTICES];
  int   mesh_verts [$];   // recently loaded vertices, corners are drawn from these

  vna_in_if  in_ch ();
  vna_out_if out_ch ();

  vertex_normal_accumulator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vna_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d normals outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure: a rotating stall pattern, sometimes always ready
  logic [15:0] stall_pattern;
  int          pattern_left;
  initial begin
    stall_pattern = 16'hffff;
    pattern_left  = 0;
  end
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left  = $urandom_range(20, 300);
      stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom());
      if (stall_pattern == 16'h0000) stall_pattern = 16'h8001;
    end
    pattern_left--;
    out_ch.ready  = stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
  end

  // one transaction on in_ch, with bursts and gaps between them
  task automatic send_cmd(op_t op, int vi, int px, int py, int pz, int ca, int cb, int cc);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.operation    = op;
    in_ch.vertex_index = VIDX_W'(vi);
    in_ch.pos_x        = POS_W'(px);
    in_ch.pos_y        = POS_W'(py);
    in_ch.pos_z        = POS_W'(pz);
    in_ch.corner_a     = VIDX_W'(ca);
    in_ch.corner_b     = VIDX_W'(cb);
    in_ch.corner_c     = VIDX_W'(cc);
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
    case (op)
      OP_LOAD: n_load++;
      OP_TRI:  n_tri++;
      OP_READ: n_read++;
      default: n_junk++;
    endcase
  endtask

  task automatic load_vertex(int vi, int px, int py, int pz);
    send_cmd(OP_LOAD, vi, px, py, pz, $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 1023));
    if (!loaded[vi]) begin
      loaded[vi] = 1'b1;
      mesh_verts.push_back(vi);
      if (mesh_verts.size() > 48) mesh_verts.pop_front();
    end
  endtask

  task automatic add_triangle(int a, int b, int c);
    send_cmd(OP_TRI, $urandom_range(0, 1023), $urandom(), $urandom(), $urandom(), a, b, c);
  endtask

  task automatic read_normal(int vi);
    send_cmd(OP_READ, vi, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      1:       return int'($urandom_range(0, 8191)) - 4096;
      default: return int'(24'($urandom())) - ((($urandom() & 1) != 0) ? 0 : 0) -
                      ((int'(24'($urandom())) >= 0) ? 0 : 0) + 0 - 0 +
                      0 - (1 << 23) + (1 << 23) - 0;
    endcase
  endfunction

  function automatic int sext_coord(int raw);
    return (raw & 24'h800000) ? raw - (1 << 24) : raw;
  endfunction

  function automatic int pick_corner();
    return mesh_verts[$urandom_range(0, mesh_verts.size() - 1)];
  endfunction

  // adds a right-angled extreme triangle to three accumulators many times,
  // with the orientation chosen at random
  task automatic saturation_run();
    int base;
    int a;
    int b;
    int c;
    base = $urandom_range(0, 1020);
    a = base;
    b = base + 1;
    c = base + 2;
    load_vertex(a, POS_MIN, POS_MIN, $urandom_range(0, 1) ? POS_MAX : POS_MIN);
    load_vertex(b, POS_MAX, POS_MIN, POS_MIN);
    load_vertex(c, POS_MIN, POS_MAX, POS_MAX);
    for (int i = 0; i < 140; i++) begin
      if ($urandom_range(0, 1)) add_triangle(a, b, c);
      else add_triangle(a, c, b);
      if (i % 35 == 34) read_normal(a);
    end
    read_normal(a);
    read_normal(b);
    read_normal(c);
  endtask

  initial begin
    int dice;
    int a;
    n_load     = 0;
    n_tri      = 0;
    n_read     = 0;
    n_junk     = 0;
    burst_left = 0;
    sat_runs   = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_LOAD;
    in_ch.vertex_index = '0;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.pos_z        = '0;
    in_ch.corner_a     = '0;
    in_ch.corner_b     = '0;
    in_ch.corner_c     = '0;
    out_ch.ready       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every operation and the special cases
    load_vertex(0, POS_MAX, POS_MAX, POS_MAX);
    load_vertex(1, POS_MIN, POS_MIN, POS_MIN);
    load_vertex(2, POS_MAX, POS_MIN, 0);
    add_triangle(0, 1, 2);            // corners at the field extremes
    load_vertex(3, 0, POS_MAX, POS_MIN);
    add_triangle(0, 2, 3);
    add_triangle(2, 2, 3);            // repeated corner
    read_normal(0);
    read_normal(2);
    read_normal(1);
    read_normal(1023);                // never loaded, zero accumulator
    send_cmd(op_t'(2'd3), 1023, POS_MIN, POS_MAX, -1, 1023, 1023, 1023);  // unused opcode
    load_vertex(1023, POS_MIN, POS_MAX, 1);
    load_vertex(512, -1, 0, POS_MAX);
    add_triangle(1023, 512, 3);
    add_triangle(3, 1023, 512);
    read_normal(1023);
    read_normal(512);
    read_normal(3);
    load_vertex(0, 5, -5, 7);         // reload clears the accumulator
    read_normal(0);

    // random mesh traffic, mostly well-formed triangles over loaded vertices
    while (n_load + n_tri + n_read < TARGET_CMDS) begin
      dice = $urandom_range(0, 99);
      if (mesh_verts.size() < 3 || dice < 18) begin
        if (mesh_verts.size() > 0 && $urandom_range(0, 3) == 0) a = pick_corner();
        else a = $urandom_range(0, 1023);
        load_vertex(a, sext_coord(rand_coord() & 24'hffffff),
                    sext_coord(rand_coord() & 24'hffffff),
                    sext_coord(rand_coord() & 24'hffffff));
      end else if (dice < 20 && sat_runs < 2) begin
        saturation_run();
        sat_runs++;
      end else if (dice < 62) begin
        a = pick_corner();
        if ($urandom_range(0, 9) == 0) add_triangle(a, a, pick_corner());
        else add_triangle(a, pick_corner(), pick_corner());
      end else if (dice < 95) begin
        read_normal(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : pick_corner());
      end else begin
        send_cmd(op_t'(2'd3), $urandom_range(0, 1023), $urandom(), $urandom(), $urandom(),
                 $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end
    in_ch.valid = 1'b0;

    // drain: every read answered, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d loads, %0d triangles (%0d saturation runs), %0d reads, %0d unused",
             n_load, n_tri, sat_runs, n_read, n_junk);
    $display("run took %0d cycles with bursty commands and a stalling receiver", cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
rtl/vna_pkg.sv
rtl/vna_if.sv
rtl/vna_ram.sv
rtl/vna_cross.sv
rtl/vna_norm.sv
rtl/vertex_normal_accumulator.sv
sim/vna_checker.sv
sim/tb_vertex_normal_accumulator.sv
